>>> rtl/core/lslc_pkg.sv
package lslc_pkg;

  localparam int NUM_REGS   = 8;
  localparam int REG_W      = 16;
  localparam int CFG_AW     = 5;
  localparam int PT_W       = 17;
  localparam int SUM_W      = 24;
  localparam int CX_W       = 36;
  localparam int CZ_W       = 33;
  localparam int SQ_W       = 37;
  localparam int ROOT_W     = 17;
  localparam int REM_W      = 20;
  localparam int IT_W       = 5;
  localparam int CORDIC_N   = 16;
  localparam int DIV_N      = SUM_W;
  localparam int SQRT_N     = ROOT_W;
  localparam int OUT_DATA_W = 72;

  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;

  typedef enum logic [2:0] {
    REG_RANGE_MIN   = 3'd0,
    REG_RANGE_MAX   = 3'd1,
    REG_ANGLE_START = 3'd2,
    REG_ANGLE_STEP  = 3'd3,
    REG_CLUSTER_GAP = 3'd4,
    REG_MOUNT_YAW   = 3'd5,
    REG_MOUNT_X     = 3'd6,
    REG_MOUNT_Y     = 3'd7
  } reg_idx_t;

  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    16'd50, 16'd8000, 16'h8000, 16'd91, 16'd150, 16'd0, 16'd0, 16'd0
  };

  // Arctangent of 2^-i in units of 1/2^30 turn.
  localparam logic [27:0] ATAN_TAB [CORDIC_N] = '{
    28'd134217728, 28'd79233351, 28'd41864727, 28'd21251189,
    28'd10666833,  28'd5338616,  28'd2669960,  28'd1335061,
    28'd667541,    28'd333772,   28'd166886,   28'd83443,
    28'd41722,     28'd20861,    28'd10430,    28'd5215
  };

  typedef enum logic [16:0] {
    ST_IDLE    = 17'h00001,
    ST_PREP    = 17'h00002,
    ST_ROT     = 17'h00004,
    ST_POST    = 17'h00008,
    ST_DIST1   = 17'h00010,
    ST_DIST2   = 17'h00020,
    ST_UPD     = 17'h00040,
    ST_FIN     = 17'h00080,
    ST_LM_INIT = 17'h00100,
    ST_LM_DIV  = 17'h00200,
    ST_LM_FIX  = 17'h00400,
    ST_LM_SQ1  = 17'h00800,
    ST_LM_SQ2  = 17'h01000,
    ST_LM_SQRT = 17'h02000,
    ST_LM_VEC  = 17'h04000,
    ST_LM_END  = 17'h08000,
    ST_EMIT    = 17'h10000
  } state_t;

  function automatic logic signed [PT_W-1:0] sat_pt(input logic signed [CX_W-1:0] v);
    if (v < -CX_W'(65536)) begin
      sat_pt = -PT_W'(65536);
    end else if (v > CX_W'(65535)) begin
      sat_pt = PT_W'(65535);
    end else begin
      sat_pt = v[PT_W-1:0];
    end
  endfunction

endpackage

>>> rtl/core/lidar_scan_landmark_clusterer_unit.sv
// Channel | Handshake          | Payload
// in_     | in_tvalid/tready   | tdata: range_mm; tuser: range_valid; tlast: scan_last
// out_    | out_tvalid/tready  | tdata: centroid_x, centroid_y, landmark_range,
//         |                    |        landmark_bearing; tuser: landmark_found;
//         |                    |        tlast: scan_done
// cfg_    | APB write/read     | eight 16-bit registers at byte address 4*i
//
// One item is worked at a time. A dropped sample leaves the sequencer idle unless it ends
// the scan; a kept point passes through the 16 rotation steps of the shared CORDIC unit.
// Each landmark adds a 24-step bit-serial divider, a 17-step two-bit-per-step square root
// and 16 vectoring steps on the same CORDIC unit.
// Reset is synchronous and active low; it restores register defaults and clears the
// cluster state. A stalled result holds the sequencer in its emit state.
module lidar_scan_landmark_clusterer_unit
  import lslc_pkg::*;
#(
  parameter int MIN_POINTS = 2,
  parameter int MAX_POINTS = 30,
  parameter int MAX_BEAMS  = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,   // [15:0] range_mm
  input  logic                  in_tuser,   // [0] range_valid
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [16:0] centroid_x, [33:17] centroid_y, [49:34] landmark_range,
  // [65:50] landmark_bearing, [71:66] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser,  // [0] landmark_found
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);

  localparam int BIW = $clog2(MAX_BEAMS);
  localparam int CW  = $clog2(MAX_POINTS + 2);

  logic [REG_W-1:0] cfg_r [NUM_REGS];
  reg_idx_t         cfg_idx;

  state_t                    state_r;
  logic [IT_W-1:0]           it_r;
  logic [15:0]               rng_in_r;
  logic                      last_r;
  logic [15:0]               ang_r;
  logic [BIW-1:0]            beam_r;
  logic                      open_r;
  logic [CW-1:0]             cnt_r;
  logic signed [SUM_W-1:0]   sumx_r, sumy_r;
  logic signed [PT_W-1:0]    prevx_r, prevy_r;
  logic signed [PT_W-1:0]    px_r, py_r;
  logic                      flip_r;
  logic                      vec_r;
  logic signed [CX_W-1:0]    xc_r, yc_r;
  logic signed [CZ_W-1:0]    zc_r;
  logic [SQ_W-1:0]           sq_r;
  logic [31:0]               gg_r;
  logic                      newc_r;
  logic                      lmdone_r;
  logic                      found_r;
  logic                      zero_r;
  logic [SUM_W-1:0]          dvx_r, dvy_r;
  logic [CW-1:0]             rmx_r, rmy_r;
  logic                      negx_r, negy_r;
  logic signed [PT_W-1:0]    cx_r, cy_r;
  logic [ROOT_W-1:0]         root_r;
  logic [REM_W-1:0]          rem_r;
  logic [15:0]               rng_r, brg_r;
  logic                      out_tvalid_r;
  logic [OUT_DATA_W-1:0]     out_tdata_r;
  logic                      out_tuser_r, out_tlast_r;

  // Combinational helpers
  logic [BIW+15:0]           ang_prod;
  logic [15:0]               ang_nxt;
  logic                      keep;
  logic                      qual;
  logic                      sigma;
  logic signed [CX_W-1:0]    xs, ys;
  logic signed [CZ_W-1:0]    atn;
  logic signed [16:0]        s17;
  logic signed [16:0]        s17_f;
  logic                      fold;
  logic signed [CX_W-1:0]    xr, yr;
  logic signed [17:0]        dx, dy;
  logic signed [35:0]        dsq;
  logic [SQ_W-1:0]           d2;
  logic [CW:0]               tx, ty;
  logic [CW-1:0]             base_cnt;
  logic signed [SUM_W-1:0]   base_sx, base_sy;
  logic [REM_W-1:0]          remt, trial;
  logic [ROOT_W:0]           root_rnd;
  logic signed [33:0]        csq;
  logic signed [CX_W-1:0]    vx0, vy0;
  logic signed [CZ_W-1:0]    zr;
  logic                      out_free;

  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {16'd0, cfg_r[cfg_idx]};

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;
  assign out_free   = !out_tvalid_r || out_tready;

  assign ang_prod = (BIW+16)'(beam_r) * (BIW+16)'(cfg_r[REG_ANGLE_STEP]);
  assign ang_nxt  = cfg_r[REG_ANGLE_START] + ang_prod[15:0] + cfg_r[REG_MOUNT_YAW];
  assign keep     = in_tuser && (in_tdata >= cfg_r[REG_RANGE_MIN])
                    && (in_tdata <= cfg_r[REG_RANGE_MAX]);
  assign qual     = open_r && (int'(cnt_r) >= MIN_POINTS) && (int'(cnt_r) <= MAX_POINTS);

  // Shared CORDIC step; rotation steers on z, vectoring on the sign of y.
  assign xs    = xc_r >>> it_r[3:0];
  assign ys    = yc_r >>> it_r[3:0];
  assign atn   = CZ_W'(ATAN_TAB[it_r[3:0]]);
  assign sigma = vec_r ? yc_r[CX_W-1] : !zc_r[CZ_W-1];

  // Fold the beam angle into a quarter turn either side of forward.
  assign s17   = {ang_r[15], ang_r};
  assign fold  = (s17 > 17'sd16384) || (s17 < -17'sd16384);
  always_comb begin
    if (s17 > 17'sd16384) begin
      s17_f = s17 - 17'sd32768;
    end else if (s17 < -17'sd16384) begin
      s17_f = s17 + 17'sd32768;
    end else begin
      s17_f = s17;
    end
  end

  assign xr = (xc_r + CX_W'(32768)) >>> 16;
  assign yr = (yc_r + CX_W'(32768)) >>> 16;

  assign dx  = {px_r[PT_W-1], px_r} - {prevx_r[PT_W-1], prevx_r};
  assign dy  = {py_r[PT_W-1], py_r} - {prevy_r[PT_W-1], prevy_r};
  assign dsq = (state_r == ST_DIST1) ? dx * dx : dy * dy;
  assign d2  = sq_r + SQ_W'($unsigned(dsq));

  assign tx = {rmx_r, dvx_r[SUM_W-1]};
  assign ty = {rmy_r, dvy_r[SUM_W-1]};

  assign base_cnt = newc_r ? '0 : cnt_r;
  assign base_sx  = newc_r ? '0 : sumx_r;
  assign base_sy  = newc_r ? '0 : sumy_r;

  assign remt     = {rem_r[REM_W-3:0], sq_r[33:32]};
  assign trial    = REM_W'({root_r, 2'b01});
  assign root_rnd = {1'b0, root_r} + ((rem_r > REM_W'(root_r)) ? 18'd1 : 18'd0);

  assign csq = (state_r == ST_LM_SQ1) ? cx_r * cx_r : cy_r * cy_r;
  assign vx0 = CX_W'(cx_r) <<< 14;
  assign vy0 = CX_W'(cy_r) <<< 14;
  assign zr  = (zc_r + CZ_W'(8192)) >>> 14;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_r[i] <= REG_RESET[i];
      end
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      cfg_r[cfg_idx] <= cfg_pwdata[REG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      it_r         <= '0;
      beam_r       <= '0;
      open_r       <= 1'b0;
      cnt_r        <= '0;
      sumx_r       <= '0;
      sumy_r       <= '0;
      prevx_r      <= '0;
      prevy_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // The emit state reloads the output register itself.
      if (out_tvalid_r && out_tready && (state_r != ST_EMIT)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            rng_in_r <= in_tdata;
            last_r   <= in_tlast;
            ang_r    <= ang_nxt;
            if (in_tlast) begin
              beam_r <= '0;
            end else if (int'(beam_r) < MAX_BEAMS - 1) begin
              beam_r <= beam_r + 1'b1;
            end
            if (keep) begin
              state_r <= ST_PREP;
            end else if (in_tlast) begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_PREP: begin
          xc_r    <= CX_W'(rng_in_r) * CX_W'(INV_GAIN_Q16);
          yc_r    <= '0;
          zc_r    <= CZ_W'(s17_f) <<< 14;
          flip_r  <= fold;
          vec_r   <= 1'b0;
          it_r    <= '0;
          state_r <= ST_ROT;
        end
        ST_ROT, ST_LM_VEC: begin
          if (sigma) begin
            xc_r <= xc_r - ys;
            yc_r <= yc_r + xs;
            zc_r <= zc_r - atn;
          end else begin
            xc_r <= xc_r + ys;
            yc_r <= yc_r - xs;
            zc_r <= zc_r + atn;
          end
          it_r <= it_r + 1'b1;
          if (int'(it_r) == CORDIC_N - 1) begin
            state_r <= (state_r == ST_ROT) ? ST_POST : ST_LM_END;
          end
        end
        ST_POST: begin
          px_r <= sat_pt((flip_r ? -xr : xr) + CX_W'($signed(cfg_r[REG_MOUNT_X])));
          py_r <= sat_pt((flip_r ? -yr : yr) + CX_W'($signed(cfg_r[REG_MOUNT_Y])));
          state_r <= ST_DIST1;
        end
        ST_DIST1: begin
          sq_r    <= SQ_W'($unsigned(dsq));
          gg_r    <= cfg_r[REG_CLUSTER_GAP] * cfg_r[REG_CLUSTER_GAP];
          state_r <= ST_DIST2;
        end
        ST_DIST2: begin
          newc_r <= !open_r || (d2 >= SQ_W'(gg_r));
          if ((!open_r || (d2 >= SQ_W'(gg_r))) && qual) begin
            lmdone_r <= 1'b0;
            state_r  <= ST_LM_INIT;
          end else begin
            state_r  <= ST_UPD;
          end
        end
        ST_UPD: begin
          open_r  <= 1'b1;
          prevx_r <= px_r;
          prevy_r <= py_r;
          if (int'(base_cnt) <= MAX_POINTS) begin
            cnt_r <= base_cnt + 1'b1;
            if (int'(base_cnt) + 1 <= MAX_POINTS) begin
              sumx_r <= base_sx + SUM_W'(px_r);
              sumy_r <= base_sy + SUM_W'(py_r);
            end else begin
              sumx_r <= base_sx;
              sumy_r <= base_sy;
            end
          end else begin
            cnt_r  <= base_cnt;
            sumx_r <= base_sx;
            sumy_r <= base_sy;
          end
          state_r <= last_r ? ST_FIN : ST_IDLE;
        end
        ST_FIN: begin
          lmdone_r <= 1'b1;
          if (qual) begin
            state_r <= ST_LM_INIT;
          end else begin
            found_r <= 1'b0;
            cx_r    <= '0;
            cy_r    <= '0;
            rng_r   <= '0;
            brg_r   <= '0;
            state_r <= ST_EMIT;
          end
        end
        ST_LM_INIT: begin
          found_r <= 1'b1;
          negx_r  <= sumx_r[SUM_W-1];
          negy_r  <= sumy_r[SUM_W-1];
          dvx_r   <= (sumx_r[SUM_W-1] ? -sumx_r : sumx_r) + SUM_W'(cnt_r >> 1);
          dvy_r   <= (sumy_r[SUM_W-1] ? -sumy_r : sumy_r) + SUM_W'(cnt_r >> 1);
          rmx_r   <= '0;
          rmy_r   <= '0;
          it_r    <= '0;
          state_r <= ST_LM_DIV;
        end
        ST_LM_DIV: begin
          // Restoring division, one quotient bit per cycle.
          if (tx >= {1'b0, cnt_r}) begin
            rmx_r <= CW'(tx - {1'b0, cnt_r});
            dvx_r <= {dvx_r[SUM_W-2:0], 1'b1};
          end else begin
            rmx_r <= tx[CW-1:0];
            dvx_r <= {dvx_r[SUM_W-2:0], 1'b0};
          end
          if (ty >= {1'b0, cnt_r}) begin
            rmy_r <= CW'(ty - {1'b0, cnt_r});
            dvy_r <= {dvy_r[SUM_W-2:0], 1'b1};
          end else begin
            rmy_r <= ty[CW-1:0];
            dvy_r <= {dvy_r[SUM_W-2:0], 1'b0};
          end
          it_r <= it_r + 1'b1;
          if (int'(it_r) == DIV_N - 1) begin
            state_r <= ST_LM_FIX;
          end
        end
        ST_LM_FIX: begin
          cx_r    <= negx_r ? -dvx_r[PT_W-1:0] : dvx_r[PT_W-1:0];
          cy_r    <= negy_r ? -dvy_r[PT_W-1:0] : dvy_r[PT_W-1:0];
          state_r <= ST_LM_SQ1;
        end
        ST_LM_SQ1: begin
          sq_r    <= SQ_W'($unsigned(csq));
          state_r <= ST_LM_SQ2;
        end
        ST_LM_SQ2: begin
          sq_r   <= sq_r + SQ_W'($unsigned(csq));
          zero_r <= (cx_r == '0) && (cy_r == '0);
          vec_r  <= 1'b1;
          if (cx_r < 0) begin
            xc_r <= -vx0;
            yc_r <= -vy0;
            zc_r <= CZ_W'(536870912);
          end else begin
            xc_r <= vx0;
            yc_r <= vy0;
            zc_r <= '0;
          end
          root_r  <= '0;
          rem_r   <= '0;
          it_r    <= '0;
          state_r <= ST_LM_SQRT;
        end
        ST_LM_SQRT: begin
          // Two radicand bits enter per cycle from bits 33:32 of the shift register.
          sq_r <= sq_r << 2;
          if (remt >= trial) begin
            rem_r  <= remt - trial;
            root_r <= {root_r[ROOT_W-2:0], 1'b1};
          end else begin
            rem_r  <= remt;
            root_r <= {root_r[ROOT_W-2:0], 1'b0};
          end
          if (int'(it_r) == SQRT_N - 1) begin
            it_r    <= '0;
            state_r <= ST_LM_VEC;
          end else begin
            it_r <= it_r + 1'b1;
          end
        end
        ST_LM_END: begin
          if (root_rnd > 18'd65535) begin
            rng_r <= 16'hFFFF;
          end else begin
            rng_r <= root_rnd[15:0];
          end
          brg_r   <= zero_r ? 16'd0 : zr[15:0];
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {6'd0, brg_r, rng_r, cy_r, cx_r};
            out_tuser_r  <= found_r;
            out_tlast_r  <= lmdone_r;
            if (lmdone_r) begin
              open_r  <= 1'b0;
              cnt_r   <= '0;
              sumx_r  <= '0;
              sumy_r  <= '0;
              prevx_r <= '0;
              prevy_r <= '0;
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_UPD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> tb/sv/tb_lidar_scan_landmark_clusterer_unit.sv
module tb_lidar_scan_landmark_clusterer_unit
  import lslc_pkg::*;
();

  localparam int MIN_PTS   = 2;
  localparam int MAX_PTS   = 30;
  localparam int BEAMS_MAX = 4096;
  localparam int SETTLE    = 150;

  typedef struct {
    bit              found;
    logic [16:0]     cx;
    logic [16:0]     cy;
    logic [15:0]     rng;
    logic [15:0]     brg;
    bit              done;
  } landmark_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;   // [15:0] range_mm
  logic                  in_tuser;   // [0] range_valid
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  // [16:0] centroid_x, [33:17] centroid_y, [49:34] landmark_range,
  // [65:50] landmark_bearing, [71:66] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;  // [0] landmark_found
  logic                  out_tlast;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_AW-1:0]     cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  lidar_scan_landmark_clusterer_unit #(
    .MIN_POINTS(MIN_PTS),
    .MAX_POINTS(MAX_PTS),
    .MAX_BEAMS(BEAMS_MAX)
  ) dut (.*);

  landmark_t   landmark_q[$];
  logic [15:0] reg_copy [NUM_REGS];
  int          mismatches;
  int          burst_left;
  int          gap_max;
  int          stall_pct;
  int          hold_left;

  // Shadow of the clustering state.
  int unsigned beam_idx;
  bit          clus_open;
  int unsigned clus_count;
  longint      sum_x, sum_y, prev_x, prev_y;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 800000);
    $display("Some tests failed");
    $finish;
  end

  function automatic longint sext16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clamp_pt(longint v);
    if (v < -65536) return -65536;
    if (v > 65535) return 65535;
    return v;
  endfunction

  function automatic void polar_to_xy(longint r, logic [15:0] ang,
                                      output longint ox, output longint oy);
    longint s, x, y, z, nx;
    bit     flip;
    s = sext16(ang);
    flip = 1'b0;
    if (s > 16384) begin
      s -= 32768;
      flip = 1'b1;
    end else if (s < -16384) begin
      s += 32768;
      flip = 1'b1;
    end
    x = r * 39797;
    y = 0;
    z = s * 16384;
    for (int i = 0; i < CORDIC_N; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z += longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    x = (x + 32768) >>> 16;
    y = (y + 32768) >>> 16;
    ox = flip ? -x : x;
    oy = flip ? -y : y;
  endfunction

  function automatic logic [15:0] bearing_to(longint cx, longint cy);
    longint x, y, z, nx;
    if (cx == 0 && cy == 0) return 16'd0;
    x = cx * 16384;
    y = cy * 16384;
    z = 0;
    if (x < 0) begin
      x = -x; y = -y; z = 536870912;
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z += longint'(ATAN_TAB[i]);
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z -= longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    z = (z + 8192) >>> 14;
    return z[15:0];
  endfunction

  function automatic logic [15:0] distance_to(longint cx, longint cy);
    longint unsigned n, root, bitv, rem;
    n = longint'(cx * cx) + longint'(cy * cy);
    root = 0;
    bitv = 64'd1 << 62;
    rem = n;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (n - root * root > root) root++;
    return (root > 65535) ? 16'hFFFF : root[15:0];
  endfunction

  function automatic longint mean_of(longint s, int unsigned n);
    longint mag, q;
    mag = (s < 0) ? -s : s;
    q = (mag + n / 2) / n;
    return (s < 0) ? -q : q;
  endfunction

  // Queues a landmark if the open cluster qualifies; reports whether it did.
  function automatic bit emit_cluster(bit done);
    landmark_t lm;
    longint    cx, cy;
    if (!clus_open || clus_count < MIN_PTS || clus_count > MAX_PTS) return 1'b0;
    cx = mean_of(sum_x, clus_count);
    cy = mean_of(sum_y, clus_count);
    lm.found = 1'b1;
    lm.cx = cx[16:0];
    lm.cy = cy[16:0];
    lm.rng = distance_to(cx, cy);
    lm.brg = bearing_to(cx, cy);
    lm.done = done;
    landmark_q.insert(landmark_q.size(), lm);
    return 1'b1;
  endfunction

  function automatic void clear_cluster();
    clus_open = 1'b0;
    clus_count = 0;
    sum_x = 0;
    sum_y = 0;
  endfunction

  function automatic void predict_beam(logic [15:0] r, bit valid, bit last);
    logic [15:0] ang;
    longint      px, py, dx, dy, g;
    landmark_t   blank;
    ang = reg_copy[REG_ANGLE_START] + 16'(beam_idx) * reg_copy[REG_ANGLE_STEP]
          + reg_copy[REG_MOUNT_YAW];
    if (beam_idx < BEAMS_MAX - 1) beam_idx++;
    if (valid && r >= reg_copy[REG_RANGE_MIN] && r <= reg_copy[REG_RANGE_MAX]) begin
      polar_to_xy(longint'(r), ang, px, py);
      px = clamp_pt(px + sext16(reg_copy[REG_MOUNT_X]));
      py = clamp_pt(py + sext16(reg_copy[REG_MOUNT_Y]));
      dx = px - prev_x;
      dy = py - prev_y;
      g = longint'(reg_copy[REG_CLUSTER_GAP]);
      if (!clus_open || dx * dx + dy * dy >= g * g) begin
        void'(emit_cluster(1'b0));
        clear_cluster();
        clus_open = 1'b1;
      end
      if (clus_count <= MAX_PTS) begin
        clus_count++;
        if (clus_count <= MAX_PTS) begin
          sum_x += px;
          sum_y += py;
        end
      end
      prev_x = px;
      prev_y = py;
    end
    if (last) begin
      if (!emit_cluster(1'b1)) begin
        blank = '{found: 1'b0, cx: '0, cy: '0, rng: '0, brg: '0, done: 1'b1};
        landmark_q.insert(landmark_q.size(), blank);
      end
      clear_cluster();
      beam_idx = 0;
      prev_x = 0;
      prev_y = 0;
    end
  endfunction

  // Sends one item and predicts its results once it has been accepted.
  task automatic send_beam(logic [15:0] r, bit valid, bit last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= r;
    in_tuser  <= valid;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_beam(r, valid, last);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(20);
      gap = (gap_max > 0) ? $urandom_range(gap_max) : 0;
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (landmark_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(idx) << 2;
    cfg_pwdata  <= {16'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    reg_copy[idx] = v;
  endtask

  task automatic setup(logic [15:0] rmin, logic [15:0] rmax, logic [15:0] a0,
                       logic [15:0] astep, logic [15:0] gap, logic [15:0] yaw,
                       logic [15:0] mx, logic [15:0] my);
    write_reg(REG_RANGE_MIN, rmin);
    write_reg(REG_RANGE_MAX, rmax);
    write_reg(REG_ANGLE_START, a0);
    write_reg(REG_ANGLE_STEP, astep);
    write_reg(REG_CLUSTER_GAP, gap);
    write_reg(REG_MOUNT_YAW, yaw);
    write_reg(REG_MOUNT_X, mx);
    write_reg(REG_MOUNT_Y, my);
  endtask

  // Result checker with its own stall pattern and long hold-off.
  initial begin
    landmark_t want;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (landmark_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %h", out_tdata);
        end else begin
          want = landmark_q.pop_front();
          if (out_tuser !== want.found || out_tdata[16:0] !== want.cx ||
              out_tdata[33:17] !== want.cy || out_tdata[49:34] !== want.rng ||
              out_tdata[65:50] !== want.brg || out_tlast !== want.done) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected f=%0d x=%h y=%h r=%h b=%h d=%0d",
                       want.found, want.cx, want.cy, want.rng, want.brg, want.done);
              $display("          got      f=%0d x=%h y=%h r=%h b=%h d=%0d",
                       out_tuser, out_tdata[16:0], out_tdata[33:17], out_tdata[49:34],
                       out_tdata[65:50], out_tlast);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic test_directed();
    setup(16'd0, 16'hFFFF, 16'd0, 16'd10, 16'd150, 16'd0, 16'h7FFF, 16'h8000);
    send_beam(16'd1000, 1'b1, 1'b0);
    send_beam(16'd1002, 1'b1, 1'b0);
    send_beam(16'd1001, 1'b1, 1'b0);
    send_beam(16'd1001, 1'b0, 1'b0);
    send_beam(16'd0, 1'b1, 1'b0);
    send_beam(16'd0, 1'b1, 1'b0);
    send_beam(16'hFFFF, 1'b1, 1'b0);
    send_beam(16'hFFFF, 1'b1, 1'b0);
    send_beam(16'hFFFF, 1'b1, 1'b1);
    drain();
    setup(16'd500, 16'd3000, 16'h8000, 16'd4096, 16'd300, 16'h4000, 16'd0, 16'd0);
    send_beam(16'd499, 1'b1, 1'b0);
    send_beam(16'd3001, 1'b1, 1'b0);
    send_beam(16'd500, 1'b1, 1'b0);
    send_beam(16'd3000, 1'b1, 1'b0);
    send_beam(16'd2000, 1'b1, 1'b1);
    send_beam(16'd2000, 1'b0, 1'b1);
    drain();
  endtask

  task automatic test_empty_window();
    setup(16'd4000, 16'd3999, 16'd0, 16'd91, 16'd150, 16'd0, 16'd0, 16'd0);
    for (int i = 0; i < 8; i++) send_beam(16'(3995 + i), 1'b1, i == 7);
    drain();
  endtask

  task automatic test_zero_gap();
    setup(16'd0, 16'hFFFF, 16'd100, 16'd0, 16'd0, 16'hC000, 16'h8000, 16'h7FFF);
    for (int i = 0; i < 6; i++) send_beam(16'd700, 1'b1, i == 5);
    drain();
  endtask

  // A cluster of exactly the maximum size, then one that overflows it.
  task automatic test_long_cluster();
    setup(16'd50, 16'd8000, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0);
    for (int i = 0; i < MAX_PTS; i++) send_beam(16'd2500, 1'b1, i == MAX_PTS - 1);
    for (int i = 0; i < MAX_PTS + 5; i++) send_beam(16'd2500, 1'b1, i == MAX_PTS + 4);
    drain();
  endtask

  // One long back-to-back scan, with a mix of dropped and kept beams.
  task automatic test_long_scan();
    setup(16'd100, 16'd5000, 16'h1234, 16'd7, 16'd150, 16'd0, 16'd0, 16'd0);
    gap_max = 0;
    for (int i = 0; i < 150; i++)
      send_beam(16'(40 + 3 * i), (i % 3) != 0, i == 149);
    gap_max = 6;
    drain();
  endtask

  // A scan of jittering ranges with occasional jumps, plus some raw noise.
  task automatic random_scan(int beams);
    logic [15:0] r;
    r = 16'($urandom_range(6000, 200));
    for (int i = 0; i < beams; i++) begin
      if ($urandom_range(9) == 0) begin
        send_beam(16'($urandom), 1'($urandom_range(1)), i == beams - 1);
      end else begin
        if ($urandom_range(7) == 0) r = 16'($urandom_range(6000, 200));
        else r = r + 16'($urandom_range(40)) - 16'd20;
        send_beam(r, $urandom_range(19) != 0, i == beams - 1);
      end
    end
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: setup(16'd50, 16'd8000, 16'h8000, 16'd91, 16'd150, 16'd0, 16'd0, 16'd0);
        1: setup(16'd0, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h7FFF,
                 16'h7FFF);
        2: setup(16'd0, 16'hFFFF, 16'h8000, 16'd0, 16'd1, 16'h8000, 16'h8000, 16'h8000);
        default: setup(16'($urandom_range(300)), 16'($urandom_range(65535, 4000)),
                       16'($urandom), 16'($urandom_range(400)),
                       16'($urandom_range(600)), 16'($urandom),
                       16'($urandom), 16'($urandom));
      endcase
      stall_pct = (phase % 3 == 0) ? 0 : $urandom_range(70);
      gap_max = (phase % 4 == 1) ? 0 : $urandom_range(12);
      for (int s = 0; s < 3; s++) random_scan($urandom_range(40, 2));
      drain();
    end
  endtask

  task automatic test_backpressure();
    setup(16'd50, 16'd8000, 16'd0, 16'd30, 16'd200, 16'd0, 16'd0, 16'd0);
    stall_pct = 20;
    gap_max = 0;
    hold_left = 1500;
    for (int s = 0; s < 6; s++) random_scan(8);
    drain();
    gap_max = 6;
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = 1'b0;
    in_tlast    = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    mismatches  = 0;
    burst_left  = 0;
    gap_max     = 6;
    stall_pct   = 30;
    hold_left   = 0;
    for (int i = 0; i < NUM_REGS; i++) reg_copy[i] = REG_RESET[i];
    beam_idx = 0;
    clear_cluster();
    prev_x = 0;
    prev_y = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // A short scan on the reset settings before any register is written.
    for (int i = 0; i < 5; i++) send_beam(16'(1500 + i), 1'b1, i == 4);
    drain();
    test_directed();
    test_empty_window();
    test_zero_gap();
    test_long_cluster();
    test_long_scan();
    test_random();
    test_backpressure();
    if (mismatches == 0 && landmark_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
